// File: hw/rtl/mfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mfb_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 64;
  localparam int ROW_BYTES    = (FRAME_WIDTH + 7) / 8;
  localparam int STORE_BYTES  = ROW_BYTES * FRAME_HEIGHT;
  localparam int ADDR_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int COL_W        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

  // Display bus command values
  localparam logic [7:0] CMD_BASE   = 8'h80;
  localparam int         HALF_ROWS  = 32;

  // Item operation codes
  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_REFRESH = 2'd3
  } mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

endpackage
`default_nettype wire

// File: hw/rtl/mfb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mfb_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [8:0] x_coord;
  logic signed [7:0] y_coord;
  logic              pixel_on;

  modport source (output valid, mode, x_coord, y_coord, pixel_on, input ready);
  modport sink   (input valid, mode, x_coord, y_coord, pixel_on, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mfb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mfb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] bus_byte;
  logic       pixel_value;
  logic       last;

  modport source (output valid, result_kind, bus_byte, pixel_value, last, input ready);
  modport sink   (input valid, result_kind, bus_byte, pixel_value, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mfb_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] lower_half_x_command;

  modport source (output valid, lower_half_x_command, input ready);
  modport sink   (input valid, lower_half_x_command, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mono_framebuffer_with_row_refresh.sv
`timescale 1ns / 1ps
`default_nettype none
// One-bit-per-pixel frame store (leftmost pixel in the byte MSB) in a byte memory
// with one write port and one registered read port, run by a small sequencer that
// handles one transaction at a time. After reset, and after every clear-store
// transaction, a clearing pass writes zero to one byte per cycle while in_ch.ready
// stays low; configuration writes are taken at any time. A pixel write inside the
// frame, or any pixel read, occupies the sequencer for a read, then a modify-write
// or a reply; a pixel write outside the frame is dropped in its accept cycle, and
// so is a refresh of a row outside the frame. A row refresh sends two command
// bytes, then one data byte per cycle while the result side does not stall, as the
// memory read port streams the row. The output register decouples the result
// side, and any stall there holds the sequencer.
module mono_framebuffer_with_row_refresh (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mfb_in_if.sink     in_ch,
  mfb_out_if.source  out_ch,
  mfb_cfg_if.sink    cfg_ch
);

  localparam logic [mfb_pkg::ADDR_W-1:0] ROW_BYTES_A = mfb_pkg::ADDR_W'(mfb_pkg::ROW_BYTES);
  localparam logic [mfb_pkg::ADDR_W-1:0] CLR_LAST    = mfb_pkg::ADDR_W'(mfb_pkg::STORE_BYTES - 1);
  localparam logic [mfb_pkg::COL_W-1:0]  COL_LAST    = mfb_pkg::COL_W'(mfb_pkg::ROW_BYTES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX,
    ST_CMD0,
    ST_CMD1,
    ST_DATA
  } state_t;

  state_t                      state_r, state_nxt;
  logic [mfb_pkg::ADDR_W-1:0]  clr_r, clr_nxt;
  logic [7:0]                  lower_x_r;
  logic [1:0]                  mode_r, mode_nxt;
  logic                        pix_on_r, pix_on_nxt;
  logic                        inb_r, inb_nxt;
  logic [2:0]                  bit_r, bit_nxt;
  logic [6:0]                  row_r, row_nxt;
  logic [mfb_pkg::ADDR_W-1:0]  base_r, base_nxt;
  logic [mfb_pkg::COL_W-1:0]   col_r, col_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  out_kind_r, out_kind_nxt;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        out_pix_r, out_pix_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [7:0]                  mem [mfb_pkg::STORE_BYTES];
  logic [7:0]                  rd_data_r;
  logic [mfb_pkg::ADDR_W-1:0]  rd_addr;
  logic                        mem_we;
  logic [mfb_pkg::ADDR_W-1:0]  mem_wa;
  logic [7:0]                  mem_wd;
  logic [mfb_pkg::COL_W-1:0]   col_rd;

  logic                        in_fire;
  logic                        out_free;
  logic [8:0]                  x_u;
  logic [7:0]                  y_u;
  logic                        x_ok;
  logic                        y_ok;
  logic [7:0]                  bit_mask;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready       = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.bus_byte    = out_byte_r;
  assign out_ch.pixel_value = out_pix_r;
  assign out_ch.last        = out_last_r;

  // Bounds check on the incoming coordinates
  assign x_u  = in_ch.x_coord;
  assign y_u  = in_ch.y_coord;
  assign x_ok = !x_u[8] && (x_u < 9'(mfb_pkg::FRAME_WIDTH));
  assign y_ok = !y_u[7] && (y_u < 8'(mfb_pkg::FRAME_HEIGHT));

  assign bit_mask = 8'h80 >> bit_r;
  assign rd_addr  = base_r + mfb_pkg::ADDR_W'(col_rd);

  // Sequencer next state, memory port control and output register load
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    mode_nxt      = mode_r;
    pix_on_nxt    = pix_on_r;
    inb_nxt       = inb_r;
    bit_nxt       = bit_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    col_nxt       = col_r;
    col_rd        = col_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_pix_nxt   = out_pix_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wa        = rd_addr;
    mem_wd        = 8'h00;

    unique case (state_r)
      ST_CLEAR: begin
        // Sweep zero through the store
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt   = in_ch.mode;
          pix_on_nxt = in_ch.pixel_on;
          inb_nxt    = x_ok && y_ok;
          bit_nxt    = x_u[2:0];
          row_nxt    = y_u[6:0];
          base_nxt   = mfb_pkg::ADDR_W'(y_u[6:0]) * ROW_BYTES_A;
          unique case (in_ch.mode)
            mfb_pkg::MODE_WRITE: begin
              col_nxt   = mfb_pkg::COL_W'(x_u[7:3]);
              state_nxt = (x_ok && y_ok) ? ST_PIX_RD : ST_IDLE;
            end
            mfb_pkg::MODE_READ: begin
              col_nxt   = mfb_pkg::COL_W'(x_u[7:3]);
              state_nxt = ST_PIX_RD;
            end
            mfb_pkg::MODE_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
              col_nxt   = '0;
              state_nxt = y_ok ? ST_CMD0 : ST_IDLE;
            end
          endcase
        end
      end

      ST_PIX_RD: begin
        // Byte address is on the read port; data lands next cycle
        state_nxt = ST_PIX;
      end

      ST_PIX: begin
        if (mode_r == mfb_pkg::MODE_WRITE) begin
          mem_we    = 1'b1;
          mem_wd    = pix_on_r ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mfb_pkg::KIND_PIXEL;
          out_byte_nxt  = 8'h00;
          out_pix_nxt   = inb_r && ((rd_data_r & bit_mask) != 8'h00);
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_CMD0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mfb_pkg::KIND_CMD;
          out_byte_nxt  = mfb_pkg::CMD_BASE + {3'b000, row_r[4:0]};
          out_pix_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_CMD1;
        end
      end

      ST_CMD1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mfb_pkg::KIND_CMD;
          out_byte_nxt  = (row_r < 7'(mfb_pkg::HALF_ROWS)) ? mfb_pkg::CMD_BASE : lower_x_r;
          out_pix_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DATA;
        end
      end

      ST_DATA: begin
        // Stream row bytes; the read port runs one byte ahead on advance
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mfb_pkg::KIND_DATA;
          out_byte_nxt  = rd_data_r;
          out_pix_nxt   = 1'b0;
          out_last_nxt  = (col_r == COL_LAST);
          col_rd        = col_r + 1'b1;
          col_nxt       = col_r + 1'b1;
          if (col_r == COL_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      lower_x_r   <= mfb_pkg::CMD_BASE;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        lower_x_r <= cfg_ch.lower_half_x_command;
      end
    end
    mode_r     <= mode_nxt;
    pix_on_r   <= pix_on_nxt;
    inb_r      <= inb_nxt;
    bit_r      <= bit_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    col_r      <= col_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

  // Frame store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

`ifndef ASSERT_OFF
  // The store is never written while a row is being streamed out
  a_no_write_in_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMD0 || state_r == ST_CMD1 || state_r == ST_DATA) |-> !mem_we)
    else $error("frame store written during row refresh");

  // A pixel reply is always the final result of its transaction
  a_pixel_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == mfb_pkg::KIND_PIXEL) |-> out_last_r)
    else $error("pixel reply without last");

  // The first data byte follows the column command
  a_cmd_before_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA && $past(state_r) == ST_CMD1) |->
      (out_valid_r && out_kind_r == mfb_pkg::KIND_CMD))
    else $error("data phase entered without column command");

  // Data bytes carry last only on the final byte of the row
  a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA && out_free) |=> (out_last_r == (state_r == ST_IDLE)))
    else $error("data byte last flag out of step with row end");
`endif

endmodule
`default_nettype wire

// File: sim/tb_mono_framebuffer_with_row_refresh.sv
`timescale 1ns / 1ps
module tb_mono_framebuffer_with_row_refresh;
  import mfb_pkg::*;

  // Cycles with no transaction anywhere before the run is abandoned
  localparam int IDLE_LIMIT  = 8000;
  // Quiet time after the last result: covers a clearing pass
  localparam int SETTLE_CYCLES = STORE_BYTES + 32;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int NUM_PHASES = 5;

  typedef struct packed {
    mode_t             mode;
    logic signed [8:0] x_coord;
    logic signed [7:0] y_coord;
    logic              pixel_on;
  } frame_op_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] bus_byte;
    logic       pixel_value;
    logic       last;
  } bus_result_t;

  logic clk;
  logic rst_n;

  mfb_in_if  in_ch ();
  mfb_out_if out_ch ();
  mfb_cfg_if cfg_ch ();

  mono_framebuffer_with_row_refresh u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the block: frame store and lower-half column command
  logic [7:0]  frame_shadow [STORE_BYTES];
  logic [7:0]  shadow_x_cmd;
  frame_op_t   pending_ops [$];
  bus_result_t due_results [$];
  frame_op_t   op_on_bus;
  int          burst_left;
  int          gap_left;
  int          fail_count;
  int          idle_cycles;
  int          stall_span;
  int          stall_style;
  int          stall_phase;
  logic [15:0] stall_mask;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic frame_op_t make_op(mode_t m, int x, int y, logic p);
    frame_op_t op;
    op.mode     = m;
    op.x_coord  = x[8:0];
    op.y_coord  = y[7:0];
    op.pixel_on = p;
    return op;
  endfunction

  function automatic bus_result_t make_result(kind_t k, logic [7:0] b, logic p, logic l);
    bus_result_t r;
    r.kind        = k;
    r.bus_byte    = b;
    r.pixel_value = p;
    r.last        = l;
    return r;
  endfunction

  // Apply one transaction to the shadow and queue the results it causes
  task automatic shadow_execute(input frame_op_t op);
    int   xi;
    int   yi;
    int   idx;
    int   bitpos;
    logic hit;
    logic [7:0] col_cmd;
    xi     = $signed(op.x_coord);
    yi     = $signed(op.y_coord);
    hit    = (xi >= 0) && (xi < FRAME_WIDTH) && (yi >= 0) && (yi < FRAME_HEIGHT);
    idx    = yi * ROW_BYTES + xi / 8;
    bitpos = 7 - (xi % 8);
    case (op.mode)
      MODE_WRITE: begin
        if (hit) frame_shadow[idx][bitpos] = op.pixel_on;
      end
      MODE_READ: begin
        due_results.push_back(make_result(KIND_PIXEL, 8'h00,
                                          hit ? frame_shadow[idx][bitpos] : 1'b0, 1'b1));
      end
      MODE_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++) frame_shadow[i] = 8'h00;
      end
      default: begin
        if (yi >= 0 && yi < FRAME_HEIGHT) begin
          col_cmd = (yi < HALF_ROWS) ? CMD_BASE : shadow_x_cmd;
          due_results.push_back(make_result(KIND_CMD, CMD_BASE + 8'(yi % HALF_ROWS),
                                            1'b0, 1'b0));
          due_results.push_back(make_result(KIND_CMD, col_cmd, 1'b0, 1'b0));
          for (int i = 0; i < ROW_BYTES; i++) begin
            due_results.push_back(make_result(KIND_DATA, frame_shadow[yi * ROW_BYTES + i],
                                              1'b0, (i == ROW_BYTES - 1)));
          end
        end
      end
    endcase
  endtask

  // Mostly in-frame traffic with rows drawn from a few bands; some noise
  function automatic frame_op_t random_frame_op();
    int sel;
    int x;
    int y;
    sel = $urandom_range(0, 99);
    x   = $urandom_range(0, FRAME_WIDTH - 1);
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0: y = $urandom_range(0, 3);
        1: y = 28 + $urandom_range(0, 3);
        2: y = 32 + $urandom_range(0, 3);
        default: y = 60 + $urandom_range(0, 3);
      endcase
    end else begin
      y = $urandom_range(0, FRAME_HEIGHT - 1);
    end
    if (sel < 45) return make_op(MODE_WRITE, x, y, ($urandom_range(0, 3) != 0));
    if (sel < 70) return make_op(MODE_READ, x, y, 1'($urandom));
    if (sel < 85) return make_op(MODE_REFRESH, 9'($urandom), y, 1'($urandom));
    if (sel < 86) return make_op(MODE_CLEAR, 9'($urandom), 8'($urandom), 1'($urandom));
    case ($urandom_range(0, 2))
      0: return make_op(MODE_WRITE, 9'($urandom), 8'($urandom), 1'($urandom));
      1: return make_op(MODE_READ, 9'($urandom), 8'($urandom), 1'($urandom));
      default: return make_op(MODE_REFRESH, 9'($urandom), 8'($urandom), 1'($urandom));
    endcase
  endfunction

  // Write the lower-half column command and mirror it in the shadow
  task automatic set_lower_x_cmd(input logic [7:0] value);
    @(posedge clk);
    cfg_ch.valid                <= 1'b1;
    cfg_ch.lower_half_x_command <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_x_cmd = value;
  endtask

  // Hold until every transaction is taken and every result has come back
  task automatic drain_and_settle();
    while (pending_ops.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive the input channel from the pending queue in bursts with gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) shadow_execute(op_on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op_on_bus = pending_ops.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.mode     <= op_on_bus.mode;
          in_ch.x_coord  <= op_on_bus.x_coord;
          in_ch.y_coord  <= op_on_bus.y_coord;
          in_ch.pixel_on <= op_on_bus.pixel_on;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel: always ready, random, or a rotating mask
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span  = $urandom_range(20, 200);
      stall_style = $urandom_range(0, 2);
      stall_mask  = 16'($urandom) | 16'h0001;
    end else begin
      stall_span--;
    end
    stall_phase = (stall_phase + 1) % 16;
    case (stall_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= stall_mask[stall_phase];
    endcase
  end

  // Compare each result transaction with the oldest one due
  always @(posedge clk) begin
    bus_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d byte 0x%02h pixel %0d last %0d",
               out_ch.result_kind, out_ch.bus_byte, out_ch.pixel_value, out_ch.last);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (out_ch.result_kind !== want.kind) begin
          $error("result_kind: expected %0d, actual %0d", want.kind, out_ch.result_kind);
          fail_count++;
        end
        if (out_ch.bus_byte !== want.bus_byte) begin
          $error("bus_byte: expected 0x%02h, actual 0x%02h", want.bus_byte, out_ch.bus_byte);
          fail_count++;
        end
        if (out_ch.pixel_value !== want.pixel_value) begin
          $error("pixel_value: expected %0d, actual %0d", want.pixel_value,
                 out_ch.pixel_value);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  // Abort when no transaction moves on any channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : main_seq
    logic [7:0] x_cmd;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_WRITE;
    in_ch.x_coord  = '0;
    in_ch.y_coord  = '0;
    in_ch.pixel_on = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.lower_half_x_command = CMD_BASE;
    shadow_x_cmd = CMD_BASE;
    burst_left   = 1;
    gap_left     = 0;
    fail_count   = 0;
    idle_cycles  = 0;
    stall_span   = 0;
    stall_style  = 0;
    stall_phase  = 0;
    stall_mask   = 16'hffff;
    for (int i = 0; i < STORE_BYTES; i++) frame_shadow[i] = 8'h00;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corners, byte edges, out-of-frame pixels and rows, clear
    pending_ops.push_back(make_op(MODE_REFRESH, 0, 0, 1'b0));
    pending_ops.push_back(make_op(MODE_WRITE, 0, 0, 1'b1));
    pending_ops.push_back(make_op(MODE_WRITE, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 1'b1));
    pending_ops.push_back(make_op(MODE_WRITE, 7, 0, 1'b1));
    pending_ops.push_back(make_op(MODE_WRITE, 8, 32, 1'b1));
    pending_ops.push_back(make_op(MODE_WRITE, -1, 0, 1'b1));
    pending_ops.push_back(make_op(MODE_WRITE, -256, 31, 1'b1));
    pending_ops.push_back(make_op(MODE_WRITE, 255, 63, 1'b1));
    pending_ops.push_back(make_op(MODE_WRITE, FRAME_WIDTH, 0, 1'b1));
    pending_ops.push_back(make_op(MODE_WRITE, 3, FRAME_HEIGHT, 1'b1));
    pending_ops.push_back(make_op(MODE_WRITE, 3, -128, 1'b1));
    pending_ops.push_back(make_op(MODE_WRITE, 7, 0, 1'b0));
    pending_ops.push_back(make_op(MODE_READ, 0, 0, 1'b0));
    pending_ops.push_back(make_op(MODE_READ, 7, 0, 1'b1));
    pending_ops.push_back(make_op(MODE_READ, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 1'b0));
    pending_ops.push_back(make_op(MODE_READ, -1, 0, 1'b0));
    pending_ops.push_back(make_op(MODE_READ, FRAME_WIDTH, 127, 1'b0));
    pending_ops.push_back(make_op(MODE_READ, 0, -1, 1'b0));
    pending_ops.push_back(make_op(MODE_REFRESH, 0, 0, 1'b0));
    pending_ops.push_back(make_op(MODE_REFRESH, 0, 31, 1'b0));
    pending_ops.push_back(make_op(MODE_REFRESH, 0, 32, 1'b0));
    pending_ops.push_back(make_op(MODE_REFRESH, -256, FRAME_HEIGHT - 1, 1'b1));
    pending_ops.push_back(make_op(MODE_REFRESH, 0, -1, 1'b0));
    pending_ops.push_back(make_op(MODE_REFRESH, 0, FRAME_HEIGHT, 1'b0));
    pending_ops.push_back(make_op(MODE_REFRESH, 0, 127, 1'b0));
    pending_ops.push_back(make_op(MODE_CLEAR, 255, -128, 1'b1));
    pending_ops.push_back(make_op(MODE_REFRESH, 0, 63, 1'b0));
    drain_and_settle();

    // Random phases under several column-command settings
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: x_cmd = 8'h88;
        1: x_cmd = 8'h00;
        2: x_cmd = 8'hff;
        3: x_cmd = 8'($urandom);
        default: x_cmd = CMD_BASE;
      endcase
      set_lower_x_cmd(x_cmd);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) pending_ops.push_back(random_frame_op());
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
